// File: hdl/touch_gesture_classifier_macros.svh
// assertion macros for the touch gesture classifier
// used by touch_gesture_classifier.sv, expects clk and rst_n in scope
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TGC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tgc_pkg.sv
// types, register indexes and reset values of the touch gesture classifier
// no dependencies
package tgc_pkg;

    localparam int COORD_BITS  = 10;
    localparam int THRESH_BITS = 10;
    localparam int TIME_BITS   = 32;
    localparam int MS_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CMP_BITS    = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;

    localparam logic [MS_BITS-1:0]     WINDOW_RESET     = MS_BITS'(500);
    localparam logic [MS_BITS-1:0]     LONG_PRESS_RESET = MS_BITS'(2000);
    localparam logic [THRESH_BITS-1:0] HTHRESH_RESET    = THRESH_BITS'(30);
    localparam logic [THRESH_BITS-1:0] VTHRESH_RESET    = THRESH_BITS'(50);
    localparam logic [THRESH_BITS-1:0] RADIUS_RESET     = THRESH_BITS'(50);
    localparam logic [MS_BITS-1:0]     HOLDOFF_RESET    = MS_BITS'(100);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW     = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_HTHRESH    = 3'd2,
        REG_VTHRESH    = 3'd3,
        REG_RADIUS     = 3'd4,
        REG_HOLDOFF    = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        GEST_NONE       = 3'd0,
        GEST_SWIPE_PX   = 3'd1,
        GEST_SWIPE_NX   = 3'd2,
        GEST_SWIPE_PY   = 3'd3,
        GEST_SWIPE_NY   = 3'd4,
        GEST_TAP        = 3'd5,
        GEST_LONG_PRESS = 3'd6
    } gesture_t;

    typedef struct packed {
        logic                  touched;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [TIME_BITS-1:0]  now_ms;
    } tgc_in_t;

    typedef struct packed {
        gesture_t              gesture;
        logic [COORD_BITS-1:0] event_x;
        logic [COORD_BITS-1:0] event_y;
    } tgc_out_t;

endpackage

// File: hdl/touch_gesture_classifier.sv
// Touch gesture classifier: takes one touch sample per transaction and returns one
// result per sample through the sample register, then the result register. A new
// sample is taken every cycle while the result register is empty or its result is
// taken; the rate is set by the two-register pipeline, with the contact state updated
// as a sample passes into the result register, so the next sample already sees it.
// Touched samples and unclassified releases give gesture none with zero coordinates.
// Configuration registers are written through their own channel, which is always ready.
// depends on tgc_pkg and touch_gesture_classifier_macros.svh
`include "touch_gesture_classifier_macros.svh"

module touch_gesture_classifier
    import tgc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  tgc_in_t                 sample,
    output logic                    result_valid,
    input  logic                    result_ready,
    output tgc_out_t                result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [MS_BITS-1:0]      cfg_data
);

    // configuration
    logic [MS_BITS-1:0]     window_reg;
    logic [MS_BITS-1:0]     long_press_reg;
    logic [THRESH_BITS-1:0] hthresh_reg;
    logic [THRESH_BITS-1:0] vthresh_reg;
    logic [THRESH_BITS-1:0] radius_reg;
    logic [MS_BITS-1:0]     holdoff_reg;

    // contact state
    logic                  contact_active_reg, contact_active_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [TIME_BITS-1:0]  start_time_reg, start_time_next;
    logic [COORD_BITS-1:0] last_x_reg, last_x_next;
    logic [COORD_BITS-1:0] last_y_reg, last_y_next;
    logic [TIME_BITS-1:0]  last_tap_time_reg, last_tap_time_next;

    // pipeline
    logic     stage_valid_reg;
    tgc_in_t  stage_reg;
    logic     result_valid_reg;
    tgc_out_t result_reg, result_next;
    logic     advance;

    // classification terms
    logic [TIME_BITS-1:0]  dur;
    logic [TIME_BITS-1:0]  since_tap;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic                  neg_x;
    logic                  neg_y;
    logic                  small_move;
    gesture_t              g;

    assign cfg_ready    = 1'b1;
    assign advance      = stage_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !stage_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= WINDOW_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            hthresh_reg    <= HTHRESH_RESET;
            vthresh_reg    <= VTHRESH_RESET;
            radius_reg     <= RADIUS_RESET;
            holdoff_reg    <= HOLDOFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW:     window_reg     <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_HTHRESH:    hthresh_reg    <= cfg_data[THRESH_BITS-1:0];
                REG_VTHRESH:    vthresh_reg    <= cfg_data[THRESH_BITS-1:0];
                REG_RADIUS:     radius_reg     <= cfg_data[THRESH_BITS-1:0];
                REG_HOLDOFF:    holdoff_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // movement and timing of the current contact
    always_comb
    begin
        dur       = stage_reg.now_ms - start_time_reg;
        since_tap = stage_reg.now_ms - last_tap_time_reg;
        neg_x     = last_x_reg < start_x_reg;
        neg_y     = last_y_reg < start_y_reg;
        ax        = neg_x ? (start_x_reg - last_x_reg) : (last_x_reg - start_x_reg);
        ay        = neg_y ? (start_y_reg - last_y_reg) : (last_y_reg - start_y_reg);
        small_move = (CMP_BITS'(ax) < CMP_BITS'(radius_reg))
                  && (CMP_BITS'(ay) < CMP_BITS'(radius_reg));
    end

    // classification and next contact state
    always_comb
    begin
        contact_active_next = contact_active_reg;
        start_x_next        = start_x_reg;
        start_y_next        = start_y_reg;
        start_time_next     = start_time_reg;
        last_x_next         = last_x_reg;
        last_y_next         = last_y_reg;
        last_tap_time_next  = last_tap_time_reg;
        g                   = GEST_NONE;

        if (stage_reg.touched)
        begin
            if (!contact_active_reg)
            begin
                contact_active_next = 1'b1;
                start_x_next        = stage_reg.pos_x;
                start_y_next        = stage_reg.pos_y;
                start_time_next     = stage_reg.now_ms;
            end
            last_x_next = stage_reg.pos_x;
            last_y_next = stage_reg.pos_y;
        end
        else if (contact_active_reg)
        begin
            contact_active_next = 1'b0;
            if (dur < TIME_BITS'(window_reg))
            begin
                if (ax > ay && CMP_BITS'(ax) > CMP_BITS'(hthresh_reg))
                    g = neg_x ? GEST_SWIPE_NX : GEST_SWIPE_PX;
                else if (ax < ay && CMP_BITS'(ay) > CMP_BITS'(vthresh_reg))
                    g = neg_y ? GEST_SWIPE_NY : GEST_SWIPE_PY;
                if (g == GEST_NONE && small_move && since_tap >= TIME_BITS'(holdoff_reg))
                begin
                    g                  = GEST_TAP;
                    last_tap_time_next = stage_reg.now_ms;
                end
            end
            else if (dur > TIME_BITS'(window_reg) && dur < TIME_BITS'(long_press_reg)
                     && small_move)
            begin
                g = GEST_LONG_PRESS;
            end
        end

        result_next.gesture = g;
        result_next.event_x = (g == GEST_NONE) ? '0 : last_x_next;
        result_next.event_y = (g == GEST_NONE) ? '0 : last_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg    <= 1'b0;
            result_valid_reg   <= 1'b0;
            contact_active_reg <= 1'b0;
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            start_time_reg     <= '0;
            last_x_reg         <= '0;
            last_y_reg         <= '0;
            last_tap_time_reg  <= '0;
        end
        else
        begin
            if (sample_ready)
                stage_valid_reg <= sample_valid;
            if (advance)
            begin
                result_valid_reg   <= 1'b1;
                contact_active_reg <= contact_active_next;
                start_x_reg        <= start_x_next;
                start_y_reg        <= start_y_next;
                start_time_reg     <= start_time_next;
                last_x_reg         <= last_x_next;
                last_y_reg         <= last_y_next;
                last_tap_time_reg  <= last_tap_time_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            stage_reg <= sample;
        if (advance)
            result_reg <= result_next;
    end

    `TGC_ASSERT_IMP(a_none_zero_coords, result_valid_reg && result_reg.gesture == GEST_NONE, result_reg.event_x == '0 && result_reg.event_y == '0, "no-gesture result carries coordinates")
    `TGC_ASSERT_NEXT(a_contact_start, advance && stage_reg.touched && !contact_active_reg, contact_active_reg && start_time_reg == $past(stage_reg.now_ms), "contact start not recorded")
    `TGC_ASSERT_NEXT(a_release_clears, advance && !stage_reg.touched, !contact_active_reg, "release left contact active")
    `TGC_ASSERT_IMP(a_empty_stage_ready, !stage_valid_reg, sample_ready, "empty sample register not ready")

endmodule
